@@ design/peak_normalize_frame_macros.svh @@
// Assertion macros used by the checker file.
`ifndef PEAK_NORMALIZE_FRAME_MACROS_SVH
`define PEAK_NORMALIZE_FRAME_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PNF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PNF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/pnf_pkg.sv @@
package pnf_pkg;

    localparam int DEFAULT_FRAME_DEPTH = 64;
    localparam int SAMPLE_W            = 16;
    localparam int TARGET_W            = 16;
    localparam int GAIN_W              = 32;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 16'h8000;

endpackage

@@ design/peak_normalize_frame.sv @@
// Frame peak normalizer. Samples of a frame (s_tdata, s_tlast on the last one) are taken one
// per cycle into a buffer of FRAME_DEPTH entries while the largest magnitude is tracked; a
// frame also closes when the buffer is full. The block then stops taking samples, computes
// gain = floor(target_level * 65536 / peak) in a bit-serial divider (one quotient bit per
// cycle), and sends the stored samples out in order as the saturated floor of sample *
// gain / 65536, with m_tlast on the last one. Each output takes four steps (buffer read,
// multiply, saturate, send), waiting in send on m_tready. An all-zero frame gives all-zero
// output. target_level is to be written through i_cfg_wr_en while the block is idle, which
// it does not enforce; it resets to 1.0 in unsigned Q1.15. No clearing pass follows reset.
module peak_normalize_frame #(
    parameter int FRAME_DEPTH = pnf_pkg::DEFAULT_FRAME_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [pnf_pkg::TARGET_W-1:0] i_cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pnf_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pnf_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
    output logic                         m_tlast
);
    import pnf_pkg::*;

    localparam int AW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FW   = $clog2(FRAME_DEPTH + 1);
    localparam int PW   = SAMPLE_W + GAIN_W + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DIV,
        S_RD,
        S_MUL,
        S_SAT,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [TARGET_W-1:0]   r_target;
    logic [SAMPLE_W-1:0]   r_mem [FRAME_DEPTH];
    logic [SAMPLE_W-1:0]   r_rd;
    logic [SAMPLE_W-1:0]   r_peak;
    logic [FW-1:0]         r_fill;
    logic [AW-1:0]         r_k;
    logic [GAIN_W-1:0]     r_gain;
    logic signed [PW-1:0]  r_prod;
    logic                  r_div_start;
    logic                  r_m_valid;
    logic                  r_m_last;
    logic [SAMPLE_W-1:0]   r_m_data;

    logic                  n_accept;
    logic [SAMPLE_W-1:0]   n_mag;
    logic [SAMPLE_W-1:0]   n_peak;
    logic [FW-1:0]         n_fill;
    logic                  n_flush;
    logic                  n_last;
    logic [SAMPLE_W-1:0]   n_sat;
    logic                  div_done;
    logic [GAIN_W-1:0]     div_quot;

    pnf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ({r_target, {(GAIN_W - TARGET_W){1'b0}}}),
        .i_divisor  (r_peak),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign n_accept = s_tvalid && s_tready;
    assign n_mag    = s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign n_peak   = (n_mag > r_peak) ? n_mag : r_peak;
    assign n_fill   = r_fill + 1'b1;
    assign n_flush  = s_tlast || (n_fill == FW'(FRAME_DEPTH));
    assign n_last   = (FW'(r_k) + FW'(1)) == r_fill;

    always_comb begin
        if (r_prod[PW-1:SAMPLE_W+SAMPLE_W-1] == '0 ||
            r_prod[PW-1:SAMPLE_W+SAMPLE_W-1] == '1) begin
            n_sat = r_prod[SAMPLE_W+SAMPLE_W-1:SAMPLE_W];
        end else if (r_prod[PW-1]) begin
            n_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            n_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_mem[r_fill[AW-1:0]] <= s_tdata;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_peak      <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
            r_m_last    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (n_accept) begin
                        r_peak <= n_peak;
                        r_fill <= n_fill;
                        if (n_flush) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_gain  <= (r_peak == '0) ? '0 : div_quot;
                        r_k     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= $signed(r_rd) * $signed({1'b0, r_gain});
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_m_data  <= n_sat;
                    r_m_last  <= n_last;
                    r_m_valid <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        r_m_valid <= 1'b0;
                        if (r_m_last) begin
                            r_peak  <= '0;
                            r_fill  <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign s_tready = (r_state == S_LOAD);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;

endmodule

@@ design/pnf_div.sv @@
module pnf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pnf_pkg::GAIN_W-1:0] i_dividend,
    input  logic [pnf_pkg::SAMPLE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pnf_pkg::GAIN_W-1:0] o_quotient
);
    import pnf_pkg::*;

    localparam int CW = $clog2(GAIN_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [SAMPLE_W-1:0]   r_rem;
    logic [SAMPLE_W-1:0]   r_div;
    logic [GAIN_W-1:0]     r_q;
    logic [SAMPLE_W:0]     n_rem_sh;
    logic [SAMPLE_W:0]     n_diff;
    logic                  n_ge;

    assign n_rem_sh = {r_rem, r_q[GAIN_W-1]};
    assign n_diff   = n_rem_sh - {1'b0, r_div};
    assign n_ge     = (n_rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[SAMPLE_W-1:0] : n_rem_sh[SAMPLE_W-1:0];
            r_q   <= {r_q[GAIN_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ design/pnf_checker.sv @@
`include "peak_normalize_frame_macros.svh"

module pnf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pnf_pkg::SAMPLE_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import pnf_pkg::*;

    `PNF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "Stalled output request changed.")

    `PNF_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "Input taken while output is pending.")

    `PNF_ASSERT(a_no_early_out, s_tvalid && s_tready && !s_tlast |=> !m_tvalid, "Output appeared right after a mid-frame sample.")

    `PNF_ASSERT(a_frame_done, m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready, "Block did not return to loading after the last output.")

endmodule

bind peak_normalize_frame pnf_checker u_pnf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
